@@ hw/rtl/box_particle_collision_macros.svh @@
// Assertion macros for the box/particle collision block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BOX_PARTICLE_COLLISION_MACROS_SVH
`define BOX_PARTICLE_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`ifndef SYNTH
`define BPC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BPC_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`endif

// Next-cycle implication, disabled while reset is asserted (active low).
`ifndef SYNTH
`define BPC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPC_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/bpc_pkg.sv @@
// Shared types, constants and helpers for the box/particle collision block.
// No dependencies; used by bpc_axis and box_particle_collision.
`default_nettype none

package bpc_pkg;

    // box_mode register codes
    typedef enum logic {
        MODE_OBSTACLE = 1'b0,
        MODE_BOUNDARY = 1'b1
    } mode_t;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_HALF_X   = 3'd3;
    localparam logic [2:0] REG_HALF_Y   = 3'd4;
    localparam logic [2:0] REG_HALF_Z   = 3'd5;
    localparam logic [2:0] REG_BOX_MODE = 3'd6;

    // normal magnitudes, signed Q2.16
    localparam logic signed [17:0] Q_ONE       = 18'sd65536;
    localparam logic signed [17:0] Q_INV_SQRT2 = 18'sd46341;
    localparam logic signed [17:0] Q_INV_SQRT3 = 18'sd37837;

    // per-axis result handed to the top level
    typedef struct packed {
        logic signed [34:0] pen;       // penetration, exact
        logic               diff_neg;  // pos - center < 0
        logic               diff_zero; // pos - center == 0
        logic signed [31:0] cont_obst; // obstacle push-out coordinate
        logic signed [31:0] cont_bnd;  // boundary push-in coordinate
    } axis_res_t;

    // clamp a 35-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic fits;
        fits = (v[34:31] == 4'b0000) || (v[34:31] == 4'b1111);
        if (fits) begin
            return v[31:0];
        end else if (v[34]) begin
            return {1'b1, 31'd0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bpc_axis.sv @@
// One axis of the sphere/box test: distance, penetration and contact candidates.
// Depends on bpc_pkg.
`default_nettype none

module bpc_axis (
    input  wire logic signed [31:0] pos,
    input  wire logic signed [31:0] center,
    input  wire logic        [30:0] half,
    input  wire logic        [23:0] radius,
    input  wire bpc_pkg::mode_t     mode,
    output bpc_pkg::axis_res_t      res
);

    logic signed [32:0] diff;
    logic signed [34:0] diff_e;
    logic signed [34:0] dabs;
    logic signed [34:0] half_e;
    logic signed [34:0] rad_e;
    logic signed [34:0] cen_e;
    logic signed [34:0] sum_hr;
    logic signed [34:0] dif_hr;

    assign diff   = {pos[31], pos} - {center[31], center};
    assign diff_e = {{2{diff[32]}}, diff};
    assign dabs   = diff[32] ? -diff_e : diff_e;
    assign half_e = {4'b0000, half};
    assign rad_e  = {11'd0, radius};
    assign cen_e  = {{3{center[31]}}, center};
    assign sum_hr = half_e + rad_e;
    assign dif_hr = half_e - rad_e;

    always_comb begin
        res.diff_neg  = diff[32];
        res.diff_zero = (diff == '0);
        unique case (mode)
            bpc_pkg::MODE_OBSTACLE: res.pen = half_e - dabs + rad_e;
            bpc_pkg::MODE_BOUNDARY: res.pen = dabs - half_e + rad_e;
            default:                res.pen = '0;
        endcase
        // obstacle: out along the side the particle sits on
        res.cont_obst = bpc_pkg::sat32(diff[32] ? cen_e - sum_hr : cen_e + sum_hr);
        // boundary: back inside, on the wall the particle crossed
        res.cont_bnd  = bpc_pkg::sat32((diff[32] || res.diff_zero) ? cen_e - dif_hr
                                                                   : cen_e + dif_hr);
    end

endmodule

`default_nettype wire

@@ hw/rtl/box_particle_collision.sv @@
// Top level of the sphere versus axis-aligned box collision block.
// Depends on bpc_pkg, bpc_axis and box_particle_collision_macros.svh.
`default_nettype none
`include "box_particle_collision_macros.svh"

// Tests one particle per item against a configurable box and returns one
// result item per input item. Throughput is one item per clock unless m_tready
// is held low. Each item passes an input register and then a result register,
// with the single pass of per-axis adders and the axis select between the two;
// m_tvalid rises once the item is in the result register. While a finished
// result waits for m_tready, one more item is still taken into the input
// register; after that s_tready stays low until the result leaves. The box
// (center, half sizes, mode) is written through the cfg_* channel, which is
// always ready; write it only while no item is in flight. Box and valid
// registers reset to zero (obstacle mode, a zero-size box at the origin).
module box_particle_collision (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write channel
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // particle input
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [119:0] s_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64],
                                         // radius[119:96]
    // collision result
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [151:0] m_tdata,   // normal_x[17:0], normal_y[35:18],
                                         // normal_z[53:36], contact_x[85:54],
                                         // contact_y[117:86], contact_z[149:118],
                                         // zero pad[151:150]
    output      logic         m_tuser    // hit[0]
);

    // ---------------- configuration ----------------
    logic signed [31:0] center_reg [3];
    logic        [30:0] half_reg   [3];
    bpc_pkg::mode_t     box_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                center_reg[i] <= '0;
                half_reg[i]   <= '0;
            end
            box_mode_reg <= bpc_pkg::MODE_OBSTACLE;
        end else if (cfg_valid && cfg_ready) begin
            // out-of-range indexes fall through and are dropped
            case (cfg_index)
                bpc_pkg::REG_CENTER_X: center_reg[0] <= cfg_data;
                bpc_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data;
                bpc_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data;
                bpc_pkg::REG_HALF_X:   half_reg[0]   <= cfg_data[30:0];
                bpc_pkg::REG_HALF_Y:   half_reg[1]   <= cfg_data[30:0];
                bpc_pkg::REG_HALF_Z:   half_reg[2]   <= cfg_data[30:0];
                bpc_pkg::REG_BOX_MODE: box_mode_reg  <= bpc_pkg::mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_adv;     // result register may load this cycle
    logic in_take;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (out_adv) begin
                in_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // ---------------- input register ----------------
    logic signed [31:0] pos_reg [3];
    logic        [23:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
            pos_reg[2] <= s_tdata[95:64];
            radius_reg <= s_tdata[119:96];
        end
    end

    // ---------------- per-axis arithmetic ----------------
    bpc_pkg::axis_res_t axis_res [3];

    for (genvar g = 0; g < 3; g++) begin : gen_axis
        bpc_axis u_axis (
            .pos    (pos_reg[g]),
            .center (center_reg[g]),
            .half   (half_reg[g]),
            .radius (radius_reg),
            .mode   (box_mode_reg),
            .res    (axis_res[g])
        );
    end

    // ---------------- hit decision and result ----------------
    logic [2:0]         pen_pos;   // penetration strictly positive
    logic [2:0]         sel_ax;    // obstacle: one-hot winning axis
    logic [1:0]         pen_cnt;
    logic signed [17:0] mag;
    logic               hit_next;
    logic signed [17:0] normal_next  [3];
    logic signed [31:0] contact_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pen_pos[i] = !axis_res[i].pen[34] && (axis_res[i].pen != '0);
        end

        // smallest penetration wins, ties to X then Y
        priority if (axis_res[0].pen <= axis_res[1].pen &&
                     axis_res[0].pen <= axis_res[2].pen) begin
            sel_ax = 3'b001;
        end else if (axis_res[1].pen <= axis_res[0].pen &&
                     axis_res[1].pen <= axis_res[2].pen) begin
            sel_ax = 3'b010;
        end else begin
            sel_ax = 3'b100;
        end

        pen_cnt = {1'b0, pen_pos[0]} + {1'b0, pen_pos[1]} + {1'b0, pen_pos[2]};
        unique case (pen_cnt)
            2'd0: mag = '0;
            2'd1: mag = bpc_pkg::Q_ONE;
            2'd2: mag = bpc_pkg::Q_INV_SQRT2;
            2'd3: mag = bpc_pkg::Q_INV_SQRT3;
        endcase

        unique case (box_mode_reg)
            bpc_pkg::MODE_OBSTACLE: hit_next = &pen_pos;
            bpc_pkg::MODE_BOUNDARY: hit_next = |pen_pos;
            default:                hit_next = 1'b0;
        endcase

        for (int i = 0; i < 3; i++) begin
            normal_next[i]  = '0;
            contact_next[i] = pos_reg[i];
            if (box_mode_reg == bpc_pkg::MODE_OBSTACLE) begin
                if (sel_ax[i]) begin
                    normal_next[i]  = axis_res[i].diff_neg ? -bpc_pkg::Q_ONE : bpc_pkg::Q_ONE;
                    contact_next[i] = axis_res[i].cont_obst;
                end
            end else begin
                if (pen_pos[i]) begin
                    normal_next[i]  = (axis_res[i].diff_neg || axis_res[i].diff_zero)
                                      ? mag : -mag;
                    contact_next[i] = axis_res[i].cont_bnd;
                end
            end
            // no hit: everything reads zero
            if (!hit_next) begin
                normal_next[i]  = '0;
                contact_next[i] = '0;
            end
        end
    end

    // ---------------- result register ----------------
    logic               hit_reg;
    logic signed [17:0] normal_reg  [3];
    logic signed [31:0] contact_reg [3];

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            hit_reg <= hit_next;
            for (int i = 0; i < 3; i++) begin
                normal_reg[i]  <= normal_next[i];
                contact_reg[i] <= contact_next[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {2'b00, contact_reg[2], contact_reg[1], contact_reg[0],
                       normal_reg[2], normal_reg[1], normal_reg[0]};

    // ---------------- checks ----------------
    `BPC_ASSERT_IMP(a_nohit_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "miss not 0")
    `BPC_ASSERT_IMP(a_hit_normal, aclk, aresetn, m_tvalid, m_tuser == (m_tdata[53:0] != '0), "hit")
    `BPC_ASSERT_IMP(a_full_stall, aclk, aresetn, in_valid_reg && !out_adv, !s_tready, "full take")
    `BPC_ASSERT_NXT(a_take_held, aclk, aresetn, in_take, in_valid_reg, "accepted item lost")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for box_particle_collision: stream stimulus against a
// built-in collision predictor. Depends on bpc_pkg and the box_particle_collision RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // handy Q16.16 extremes for the directed table
    localparam int FIX_MAX = 32'h7FFF_FFFF;
    localparam int FIX_MIN = 32'h8000_0000;
    localparam int RAD_MAX = 24'hFF_FFFF;
    localparam int HALF_MAX = 31'h7FFF_FFFF;
    localparam logic [2:0] REG_UNUSED = 3'd7;  // no register behind it, write must be ignored
    localparam int HOLD_CYCLES = 60;           // long back-pressure stretch on the result side
    localparam int DRAIN_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 50;

    // one input item: pos x in the low word, radius on top, as on s_tdata
    typedef struct packed {
        logic [23:0]      radius;
        logic [2:0][31:0] pos;
    } particle_t;

    // one result item; the two arrays line up with m_tdata[149:0]
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] contact;
        logic [2:0][17:0] normal;
    } collision_t;

    typedef struct packed {
        bpc_pkg::mode_t   mode;
        logic [2:0][30:0] half;
        logic [2:0][31:0] center;
    } box_t;

    typedef struct packed {
        box_t       box;
        particle_t  p;
        logic       typed;   // 1: expected result given in the row, 0: predicted
        collision_t want;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tuser;

    // box as the block should currently hold it
    longint         box_center [3];
    longint         box_half [3];
    bpc_pkg::mode_t box_mode;
    box_t           cur_box;

    collision_t    pending [$];   // collisions expected, oldest first
    directed_row_t rows [$];
    int            fail_count = 0;
    int            idle_pct = 6;
    int            hold_asked = 0;
    int            hold_taken = 0;
    int            hold_left = 0;
    string         axis_names = "xyz";

    box_particle_collision i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint clamp32(input longint v);
        if (v > longint'(FIX_MAX)) begin
            return longint'(FIX_MAX);
        end else if (v < longint'(FIX_MIN)) begin
            return longint'(FIX_MIN);
        end
        return v;
    endfunction

    // Sphere against box, exact 64-bit arithmetic.
    // Obstacle: all three penetrations positive, shallowest axis pushed out
    // (ties go x, then y, then z). Boundary: every penetrating axis pushed
    // back in, normal scaled by 1, 1/sqrt2 or 1/sqrt3.
    function automatic collision_t predict_collision(input particle_t p);
        longint     pos [3];
        longint     pen [3];
        longint     dir [3];
        longint     cont [3];
        longint     rad;
        longint     gap;
        longint     mag;
        int         n_axes;
        int         ax;
        collision_t r;
        r = '0;
        n_axes = 0;
        rad = longint'(p.radius);
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(p.pos[i]));
            gap = box_center[i] - pos[i];
            if (gap < 0) gap = -gap;
            if (box_mode == bpc_pkg::MODE_OBSTACLE) begin
                pen[i] = box_half[i] - gap + rad;
            end else begin
                pen[i] = gap - box_half[i] + rad;
            end
            dir[i] = 0;
            cont[i] = pos[i];
            if (box_mode == bpc_pkg::MODE_BOUNDARY && pen[i] > 0) begin
                n_axes++;
                // on the centre itself the push goes towards +
                dir[i] = (pos[i] - box_center[i] <= 0) ? 1 : -1;
                cont[i] = clamp32(box_center[i] - dir[i] * (box_half[i] - rad));
            end
        end
        if (box_mode == bpc_pkg::MODE_OBSTACLE &&
            pen[0] > 0 && pen[1] > 0 && pen[2] > 0) begin
            n_axes = 1;
            if (pen[0] <= pen[1] && pen[0] <= pen[2]) begin
                ax = 0;
            end else if (pen[1] <= pen[2]) begin
                ax = 1;
            end else begin
                ax = 2;
            end
            dir[ax] = (pos[ax] - box_center[ax] >= 0) ? 1 : -1;
            cont[ax] = clamp32(box_center[ax] + dir[ax] * (box_half[ax] + rad));
        end
        mag = (n_axes == 1) ? bpc_pkg::Q_ONE :
              (n_axes == 2) ? bpc_pkg::Q_INV_SQRT2 : bpc_pkg::Q_INV_SQRT3;
        if (n_axes != 0) begin
            r.hit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                r.normal[i] = 18'(dir[i] * mag);
                r.contact[i] = 32'(cont[i]);
            end
        end
        return r;
    endfunction

    // row builders for the directed table
    function automatic box_t box_of(input int cx, cy, cz, hx, hy, hz,
                                    input bpc_pkg::mode_t m);
        box_t b;
        b.center = {32'(cz), 32'(cy), 32'(cx)};
        b.half = {31'(hz), 31'(hy), 31'(hx)};
        b.mode = m;
        return b;
    endfunction

    function automatic particle_t particle_at(input int px, py, pz, rad);
        particle_t p;
        p.pos = {32'(pz), 32'(py), 32'(px)};
        p.radius = 24'(rad);
        return p;
    endfunction

    function automatic collision_t result_of(input int hit, nx, ny, nz, cx, cy, cz);
        collision_t r;
        r.hit = 1'(hit);
        r.normal = {18'(nz), 18'(ny), 18'(nx)};
        r.contact = {32'(cz), 32'(cy), 32'(cx)};
        return r;
    endfunction

    // Called at a falling edge, returns at a falling edge with cfg_valid
    // still high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            bpc_pkg::REG_CENTER_X, bpc_pkg::REG_CENTER_Y, bpc_pkg::REG_CENTER_Z: begin
                box_center[idx] = longint'($signed(val));
            end
            bpc_pkg::REG_HALF_X, bpc_pkg::REG_HALF_Y, bpc_pkg::REG_HALF_Z: begin
                box_half[idx - bpc_pkg::REG_HALF_X] = longint'(val[30:0]);
            end
            bpc_pkg::REG_BOX_MODE: begin
                box_mode = bpc_pkg::mode_t'(val[0]);
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Whole box in one go. Junk in the unused top bits and a write to the
    // empty index must leave the box untouched.
    task automatic set_box(input box_t b);
        write_reg(bpc_pkg::REG_CENTER_X, b.center[0]);
        write_reg(bpc_pkg::REG_CENTER_Y, b.center[1]);
        write_reg(bpc_pkg::REG_CENTER_Z, b.center[2]);
        write_reg(bpc_pkg::REG_HALF_X, {1'($urandom_range(1)), b.half[0]});
        write_reg(bpc_pkg::REG_HALF_Y, {1'($urandom_range(1)), b.half[1]});
        write_reg(bpc_pkg::REG_HALF_Z, {1'($urandom_range(1)), b.half[2]});
        write_reg(bpc_pkg::REG_BOX_MODE, {31'($urandom), b.mode});
        write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        cur_box = b;
    endtask

    // Called at a falling edge, returns at the falling edge after the item
    // went in, with s_tvalid left high for a possible next item.
    task automatic send_particle(input particle_t p, input logic typed, input collision_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.radius, p.pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending.push_back(typed ? want : predict_collision(p));
        @(negedge aclk);
    endtask

    // wait for every outstanding collision, bounded
    task automatic drain_results();
        int w;
        w = 0;
        while (pending.size() != 0 && w < DRAIN_LIMIT) begin
            @(negedge aclk);
            w++;
        end
        if (pending.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending.size()));
            pending.delete();
        end
    endtask

    // Mostly moderate boxes so that hits are frequent; now and then full
    // range centres and half sizes, and equal halves to provoke axis ties.
    function automatic box_t random_box(input bpc_pkg::mode_t m);
        box_t b;
        int   scale;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(7) == 0) begin
                b.center[i] = $urandom;
            end else begin
                b.center[i] = 32'($signed($urandom) >>> $urandom_range(8, 20));
            end
            scale = $urandom_range(12, 22);
            b.half[i] = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom >> (32 - scale));
        end
        if ($urandom_range(2) == 0) begin
            b.half[1] = b.half[0];
            b.half[2] = b.half[0];
        end
        b.mode = m;
        return b;
    endfunction

    // Particles mostly scattered around the current box, straddling its faces;
    // some land on the centre plane, some mirror x to provoke ties, and a few
    // are drawn from the whole range.
    function automatic particle_t random_particle();
        particle_t      p;
        longint         span;
        longint         off [3];
        longint unsigned draw;
        p.radius = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
        if ($urandom_range(7) == 0) begin
            p.pos = {$urandom, $urandom, $urandom};
            return p;
        end
        for (int i = 0; i < 3; i++) begin
            span = box_half[i] + longint'(p.radius) + (box_half[i] >>> 2) + 4;
            draw = {$urandom, $urandom};
            off[i] = longint'(draw % longint'(2 * span + 1)) - span;
            if ($urandom_range(9) == 0) off[i] = 0;
        end
        if ($urandom_range(7) == 0) begin
            off[1] = off[0];
            off[2] = -off[0];
        end
        for (int i = 0; i < 3; i++) begin
            p.pos[i] = 32'(clamp32(box_center[i] + off[i]));
        end
        return p;
    endfunction

    // Directed table: reset box first, then a unit container and boxes at the
    // range limits in both modes. Rows whose answer is plain from the spec carry
    // it; the rest (axis choice, ties, diagonal normals) go through the predictor.
    function automatic void load_directed();
        box_t rst, big, lo, unit, hi_b, lo_b;
        rst  = box_of(0, 0, 0, 0, 0, 0, bpc_pkg::MODE_OBSTACLE);
        big  = box_of(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX, bpc_pkg::MODE_OBSTACLE);
        lo   = box_of(FIX_MIN, FIX_MIN, FIX_MIN, 0, 0, 0, bpc_pkg::MODE_OBSTACLE);
        unit = box_of(0, 0, 0, 65536, 65536, 65536, bpc_pkg::MODE_BOUNDARY);
        hi_b = box_of(FIX_MAX, FIX_MAX, FIX_MAX, 0, 0, 0, bpc_pkg::MODE_BOUNDARY);
        lo_b = box_of(FIX_MIN, FIX_MIN, FIX_MIN, HALF_MAX, HALF_MAX, HALF_MAX,
                      bpc_pkg::MODE_BOUNDARY);
        // zero-size box after reset: touching only is no hit, radius 1 is
        rows.push_back('{rst, particle_at(0, 0, 0, 0), 1'b1, '0});
        rows.push_back('{rst, particle_at(0, 0, 0, 1), 1'b1,
                         result_of(1, bpc_pkg::Q_ONE, 0, 0, 1, 0, 0)});
        rows.push_back('{rst, particle_at(FIX_MAX, FIX_MAX, FIX_MAX, RAD_MAX), 1'b1, '0});
        rows.push_back('{rst, particle_at(FIX_MIN, FIX_MIN, FIX_MIN, RAD_MAX), 1'b1, '0});
        // huge obstacle: corners saturate the push-out, x wins the three-way tie
        rows.push_back('{big, particle_at(FIX_MAX, FIX_MAX, FIX_MAX, RAD_MAX), 1'b1,
                         result_of(1, bpc_pkg::Q_ONE, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX)});
        rows.push_back('{big, particle_at(FIX_MIN, FIX_MIN, FIX_MIN, RAD_MAX), 1'b1,
                         result_of(1, -bpc_pkg::Q_ONE, 0, 0, FIX_MIN, FIX_MIN, FIX_MIN)});
        rows.push_back('{big, particle_at(FIX_MIN, FIX_MIN, FIX_MIN, 0), 1'b1, '0});
        rows.push_back('{big, particle_at(0, 10, 20, 0), 1'b0, '0});    // z shallowest
        rows.push_back('{big, particle_at(0, 20, 10, 0), 1'b0, '0});    // y shallowest
        rows.push_back('{big, particle_at(0, -7, 7, 0), 1'b0, '0});     // y and z tie
        rows.push_back('{lo, particle_at(FIX_MIN, FIX_MIN, FIX_MIN, 1), 1'b0, '0});
        // unit container: inside, one wall, two walls, corner, exactly on a wall
        rows.push_back('{unit, particle_at(0, 0, 0, 0), 1'b1, '0});
        rows.push_back('{unit, particle_at(131072, 0, 0, 0), 1'b1,
                         result_of(1, -bpc_pkg::Q_ONE, 0, 0, 65536, 0, 0)});
        rows.push_back('{unit, particle_at(-131072, 131072, 0, 0), 1'b0, '0});
        rows.push_back('{unit, particle_at(-131072, -131072, -131072, 0), 1'b0, '0});
        rows.push_back('{unit, particle_at(65536, 0, 0, 0), 1'b0, '0});
        rows.push_back('{unit, particle_at(65536, 0, 0, 1), 1'b0, '0});
        rows.push_back('{unit, particle_at(0, 0, 0, RAD_MAX), 1'b0, '0}); // radius beyond the walls
        // containers pinned to the range limits; the push-in saturates for the high one
        rows.push_back('{hi_b, particle_at(FIX_MIN, FIX_MIN, FIX_MIN, RAD_MAX), 1'b0, '0});
        rows.push_back('{lo_b, particle_at(FIX_MAX, FIX_MAX, FIX_MAX, 0), 1'b0, '0});
    endfunction

    // Result side: random back-pressure, plus one long hold-off when asked
    // for, so the block fills up and has to stall its input.
    always @(negedge aclk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Every accepted result item against the oldest expectation, field by field.
    always @(posedge aclk) begin : check_results
        collision_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser;
            got.normal = m_tdata[53:0];
            got.contact = m_tdata[149:54];
            if (pending.size() == 0) begin
                flag_error("result item with nothing expected");
            end else begin
                want = pending.pop_front();
                if (got.hit !== want.hit) begin
                    flag_error($sformatf("hit: got %b, expected %b", got.hit, want.hit));
                end
                for (int i = 0; i < 3; i++) begin
                    if (got.normal[i] !== want.normal[i]) begin
                        flag_error($sformatf("normal_%c: got %0d, expected %0d", axis_names[i],
                                             $signed(got.normal[i]), $signed(want.normal[i])));
                    end
                    if (got.contact[i] !== want.contact[i]) begin
                        flag_error($sformatf("contact_%c: got %0d, expected %0d", axis_names[i],
                                             $signed(got.contact[i]), $signed(want.contact[i])));
                    end
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        for (int i = 0; i < 3; i++) begin
            box_center[i] = 0;
            box_half[i] = 0;
        end
        box_mode = bpc_pkg::MODE_OBSTACLE;
        cur_box = '0;
        load_directed();

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part; a new box only once the previous one has no items in flight
        foreach (rows[n]) begin
            if (rows[n].box != cur_box) begin
                s_tvalid <= 1'b0;
                drain_results();
                set_box(rows[n].box);
            end
            send_particle(rows[n].p, rows[n].typed, rows[n].want);
        end
        s_tvalid <= 1'b0;

        // random part: a fresh box per phase, modes alternating; two phases
        // run with no idling at all, one carries the long hold-off
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            idle_pct = (phase == 4 || phase == 5) ? 0 : 6;
            set_box(random_box(phase[0] ? bpc_pkg::MODE_BOUNDARY : bpc_pkg::MODE_OBSTACLE));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 2 && k == 10) hold_asked++;
                send_particle(random_particle(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        drain_results();
        repeat (10) @(negedge aclk);   // catch any stray result beyond the pipeline depth
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #400_000;
        $display("ERROR: timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_axis.sv
hw/rtl/box_particle_collision.sv
tb/testbench.sv
